// File: rtl/mpid_pkg.sv
`timescale 1ns / 1ps
// mpid_pkg: shared types and constants of the multichannel pid controller
// no dependencies

package mpid_pkg;

    localparam int ERR_W     = 17;
    localparam int INTEG_W   = 25;
    localparam int DRIVE_W   = 32;
    localparam int GAIN_W    = 24;
    localparam int OP_W      = 25;
    localparam int PROD_W    = GAIN_W + OP_W;
    localparam int TERM_W    = PROD_W - 12;
    localparam int SUM_W     = 40;
    localparam int CH_W      = 3;
    localparam int CH_EXT_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 32;
    localparam int DLIM_W    = 31;
    localparam int ILIM_W    = 24;

    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [INTEG_W-1:0] t_integ;
    typedef logic signed [DRIVE_W-1:0] t_drive;
    typedef logic signed [OP_W-1:0]    t_op;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef struct packed {
        t_err   e0;
        t_err   e1;
        t_err   e2;
        t_integ integ;
    } t_err_entry;

    localparam int ENTRY_W = $bits(t_err_entry);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_MODE           = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_DRIVE_LIMIT    = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        FUNC_STEP  = 1'b0,
        FUNC_CLEAR = 1'b1
    } t_func;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

endpackage

// File: rtl/multichannel_pid_controller_core.sv
`timescale 1ns / 1ps
// multichannel_pid_controller_core: top level of the multichannel pid controller
// uses mpid_pkg and mpid_state_ram
//
// usage
//   input channel: i_in_valid / o_in_stall carry one request (func, channel,
//   setpoint, measured). a step request runs one pid update for the channel,
//   a clear request zeroes its history and drive.
//   output channel: o_out_valid / i_out_stall carry one result per request
//   (channel_out, drive, error_now), in request order.
//   config channel: i_cfg_valid / o_cfg_ready, always ready; write only while
//   no request is in flight.
// timing
//   a registered pipeline of read, operand, multiply and sum stages feeds an
//   output register. one request is taken every cycle while the output is not
//   stalled; forwarding on the error memory and on the drive memory lets requests
//   to the same channel follow each other directly.
// reset
//   synchronous reset clears config to defaults and marks every channel entry
//   as zero; requests are taken in the first cycle after reset.
// stall
//   while a result waits under i_out_stall the whole pipeline holds and
//   o_in_stall is high; otherwise o_in_stall is low.

module multichannel_pid_controller_core
    import mpid_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [CH_W-1:0]      i_channel,
    input  logic signed [15:0]   i_setpoint,
    input  logic signed [15:0]   i_measured,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_W-1:0]      o_channel_out,
    output logic signed [31:0]   o_drive,
    output logic signed [16:0]   o_error_now,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0]    i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_EXT_W-1:0] CH_LIM = CH_EXT_W'(CHANNELS);

    function automatic t_term trunc_q12(input t_prod p);
        t_prod q;
        q = p + (p[PROD_W-1] ? t_prod'(4095) : t_prod'(0));
        return q[PROD_W-1:12];
    endfunction

    // configuration
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    t_mode                    r_mode;
    logic [ILIM_W-1:0]        r_integral_limit;
    logic [DLIM_W-1:0]        r_drive_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= '0;
            r_gain_i         <= '0;
            r_gain_d         <= '0;
            r_mode           <= MODE_POSITIONAL;
            r_integral_limit <= '0;
            r_drive_limit    <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_P:         r_gain_p         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         r_gain_i         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         r_gain_d         <= i_cfg_data[GAIN_W-1:0];
                CFG_MODE:           r_mode           <= t_mode'(i_cfg_data[0]);
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[ILIM_W-1:0];
                CFG_DRIVE_LIMIT:    r_drive_limit    <= i_cfg_data[DLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic r_out_vld;
    logic adv;

    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = !adv;

    logic                  in_acc;
    logic [CH_EXT_W-1:0]   in_ch_ext;
    logic [AW-1:0]         in_idx;

    assign in_acc    = i_in_valid && adv;
    assign in_ch_ext = CH_EXT_W'(i_channel);
    assign in_idx    = in_ch_ext[AW-1:0];

    // stage 1: error memory data returns, operands formed, history written back
    logic                r_s1_vld;
    t_func               r_s1_func;
    logic [CH_W-1:0]     r_s1_ch;
    logic                r_s1_inr;
    logic signed [15:0]  r_s1_sp, r_s1_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func <= t_func'(i_func);
            r_s1_ch   <= i_channel;
            r_s1_inr  <= in_ch_ext < CH_LIM;
            r_s1_sp   <= i_setpoint;
            r_s1_ms   <= i_measured;
        end
    end

    logic [CH_EXT_W-1:0] s1_ch_ext;
    logic [AW-1:0]       s1_idx;
    logic [ENTRY_W-1:0]  err_rdata;
    t_err_entry          st;
    t_err_entry          n_entry;
    logic                err_we;
    t_err                n_e;
    logic signed [ERR_W:0]   n_d1;
    logic signed [ERR_W+1:0] n_dd;
    logic signed [INTEG_W:0] n_isum, n_ilim, n_iclamp;
    t_op                 n_op_a, n_op_b, n_op_c;
    logic                n_zero;

    assign s1_ch_ext = CH_EXT_W'(r_s1_ch);
    assign s1_idx    = s1_ch_ext[AW-1:0];
    assign st        = t_err_entry'(err_rdata);
    assign err_we    = r_s1_vld && r_s1_inr;

    always_comb begin
        n_e      = t_err'(r_s1_sp) - t_err'(r_s1_ms);
        n_d1     = (ERR_W+1)'(n_e) - (ERR_W+1)'(st.e0);
        n_dd     = (ERR_W+2)'(n_e) - ((ERR_W+2)'(st.e0) <<< 1) + (ERR_W+2)'(st.e1);
        n_isum   = (INTEG_W+1)'(st.integ) + (INTEG_W+1)'(n_e);
        n_ilim   = $signed({2'b00, r_integral_limit});
        if (n_isum > n_ilim) begin
            n_iclamp = n_ilim;
        end else if (n_isum < -n_ilim) begin
            n_iclamp = -n_ilim;
        end else begin
            n_iclamp = n_isum;
        end
        n_zero = (r_s1_func == FUNC_CLEAR) || !r_s1_inr;
        if (r_mode == MODE_INCREMENTAL) begin
            n_op_a  = OP_W'(n_d1);
            n_op_b  = OP_W'(n_e);
            n_op_c  = OP_W'(n_dd);
            n_entry = '{e0: n_e, e1: st.e0, e2: st.e1, integ: st.integ};
        end else begin
            n_op_a  = OP_W'(n_e);
            n_op_b  = n_iclamp[INTEG_W-1:0];
            n_op_c  = OP_W'(n_d1);
            n_entry = '{e0: n_e, e1: st.e0, e2: st.e2, integ: n_iclamp[INTEG_W-1:0]};
        end
        if (r_s1_func == FUNC_CLEAR) begin
            n_entry = '0;
        end
    end

    mpid_state_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (ENTRY_W),
        .AW    (AW)
    ) u_err_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_we    (err_we),
        .i_waddr (s1_idx),
        .i_wdata (n_entry),
        .i_raddr (in_idx),
        .o_rdata (err_rdata)
    );

    // stage 2: multiplies, drive memory read issued
    logic            r_s2_vld;
    logic [CH_W-1:0] r_s2_ch;
    logic            r_s2_inr;
    logic            r_s2_zero;
    t_err            r_s2_e;
    t_op             r_s2_a, r_s2_b, r_s2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_inr  <= r_s1_inr;
            r_s2_zero <= n_zero;
            r_s2_e    <= n_zero ? '0 : n_e;
            r_s2_a    <= n_op_a;
            r_s2_b    <= n_op_b;
            r_s2_c    <= n_op_c;
        end
    end

    logic [CH_EXT_W-1:0] s2_ch_ext;
    logic [AW-1:0]       s2_idx;
    t_prod               n_pa, n_pb, n_pc;

    assign s2_ch_ext = CH_EXT_W'(r_s2_ch);
    assign s2_idx    = s2_ch_ext[AW-1:0];

    always_comb begin
        n_pa = r_gain_p * r_s2_a;
        n_pb = r_gain_i * r_s2_b;
        n_pc = r_gain_d * r_s2_c;
    end

    // stage 3: truncate, sum, saturate, drive written back
    logic            r_s3_vld;
    logic [CH_W-1:0] r_s3_ch;
    logic            r_s3_inr;
    logic            r_s3_zero;
    t_err            r_s3_e;
    t_prod           r_s3_pa, r_s3_pb, r_s3_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_ch   <= r_s2_ch;
            r_s3_inr  <= r_s2_inr;
            r_s3_zero <= r_s2_zero;
            r_s3_e    <= r_s2_e;
            r_s3_pa   <= n_pa;
            r_s3_pb   <= n_pb;
            r_s3_pc   <= n_pc;
        end
    end

    logic [CH_EXT_W-1:0] s3_ch_ext;
    logic [AW-1:0]       s3_idx;
    logic [DRIVE_W-1:0]  drv_rdata;
    logic                drv_we;
    t_sum                n_acc, n_sum, n_dlim, n_clamp;
    t_drive              n_drive;

    assign s3_ch_ext = CH_EXT_W'(r_s3_ch);
    assign s3_idx    = s3_ch_ext[AW-1:0];
    assign drv_we    = r_s3_vld && r_s3_inr;

    always_comb begin
        n_acc  = (r_mode == MODE_INCREMENTAL) ? SUM_W'(t_drive'(drv_rdata)) : '0;
        n_sum  = n_acc + SUM_W'(trunc_q12(r_s3_pa)) + SUM_W'(trunc_q12(r_s3_pb))
               + SUM_W'(trunc_q12(r_s3_pc));
        n_dlim = $signed({(SUM_W-DLIM_W)'(0), r_drive_limit});
        if (n_sum > n_dlim) begin
            n_clamp = n_dlim;
        end else if (n_sum < -n_dlim) begin
            n_clamp = -n_dlim;
        end else begin
            n_clamp = n_sum;
        end
        n_drive = r_s3_zero ? '0 : n_clamp[DRIVE_W-1:0];
    end

    mpid_state_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (DRIVE_W),
        .AW    (AW)
    ) u_drv_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_we    (drv_we),
        .i_waddr (s3_idx),
        .i_wdata (n_drive),
        .i_raddr (s2_idx),
        .o_rdata (drv_rdata)
    );

    // output register
    logic [CH_W-1:0] r_out_ch;
    t_drive          r_out_drive;
    t_err            r_out_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_ch    <= r_s3_ch;
            r_out_drive <= n_drive;
            r_out_e     <= r_s3_e;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_channel_out = r_out_ch;
    assign o_drive       = r_out_drive;
    assign o_error_now   = r_out_e;

endmodule

// File: rtl/mpid_state_ram.sv
`timescale 1ns / 1ps
// mpid_state_ram: per-channel state memory, one write and one registered read port
// valid bit per entry reads unwritten entries as zero; same-cycle write is forwarded

module mpid_state_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_fwd;
    logic             r_hit;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_q   <= r_mem[i_raddr];
            r_fwd <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_hit    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (i_en) begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_hit    <= i_we && (i_waddr == i_raddr);
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_hit ? r_fwd : (r_rd_vld ? r_q : '0);

endmodule

// File: rtl/mpid_checker.sv
`timescale 1ns / 1ps
// mpid_checker: port-level assertions for multichannel_pid_controller_core
// uses mpid_pkg; bound to the top level at the end of this file

module mpid_checker
    import mpid_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [CH_W-1:0]      o_channel_out,
    input logic signed [31:0]   o_drive,
    input logic signed [16:0]   o_error_now
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_drive) && $stable(o_channel_out)
            && $stable(o_error_now))
        else $error("stalled result changed");

    // input only stalls while a result is held
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && i_out_stall) |-> !o_in_stall)
        else $error("request stalled without output backpressure");

    // saturation never yields the most negative drive
    a_drive_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive != 32'sh8000_0000)
        else $error("drive outside symmetric limit");

    // difference of two 16-bit values never reaches the 17-bit minimum
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_now != 17'sh1_0000)
        else $error("error value out of range");

endmodule

bind multichannel_pid_controller_core mpid_checker u_mpid_checker (.*);
